// ===== hw/rtl/anti_mcmullen_escape_time_top_defines.svh =====
// ----------------------------------------------------------------------------
// Escape-time block assertion macros
// Shared assertion shorthands for the escape-time RTL.
// ----------------------------------------------------------------------------
`ifndef ANTI_MCMULLEN_ESCAPE_TIME_TOP_DEFINES_SVH
`define ANTI_MCMULLEN_ESCAPE_TIME_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define AMET_ASSERT_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("same-cycle check failed");

// next-cycle implication, sampled on clk, off during rst
`define AMET_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/amet_pkg.sv =====
// ----------------------------------------------------------------------------
// amet_pkg
// Types, codes, constants and microprogram for the escape-time block.
// ----------------------------------------------------------------------------
package amet_pkg;

  localparam logic signed [63:0] FX_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] FX_MIN   = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] ESC_NORM = 64'sh0064_0000_0000_0000;
  localparam logic [127:0]       RND_HALF = 128'h1 << 47;
  localparam logic [3:0]         MAX_EXPONENT = 4'd8;
  localparam logic [11:0]        EV_NONE = 12'hFFF;

  typedef logic [5:0] pc_t;
  localparam pc_t PC_LD_END   = 6'd3;
  localparam pc_t PC_NORM     = 6'd4;
  localparam pc_t PC_NORM_END = 6'd6;
  localparam pc_t PC_STEP     = 6'd7;
  localparam pc_t PC_LOOP     = 6'd15;
  localparam pc_t PC_LOOP_END = 6'd25;
  localparam pc_t PC_STEP_END = 6'd38;

  typedef enum logic [2:0] {
    REG_C_REAL = 3'd0, REG_C_IMAG = 3'd1, REG_EXP_N = 3'd2,
    REG_EXP_M = 3'd3, REG_MAX_IT = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_LD, OP_MOV, OP_NEG, OP_ADD, OP_SUB, OP_MUL, OP_DIV,
    OP_MOVN, OP_MOVM, OP_LOOP
  } op_t;

  typedef enum logic [3:0] {
    R_XR, R_XI, R_CR, R_CI, R_PR, R_PI, R_Y1R, R_Y1I,
    R_Y2R, R_Y2I, R_KR, R_KI, R_T0, R_T1, R_T2, R_T3
  } rsel_t;

  typedef enum logic [1:0] {LD_C_RE, LD_C_IM, LD_PT_RE, LD_PT_IM} ld_t;

  typedef struct packed {
    op_t   op;
    rsel_t dst;
    rsel_t a;
    rsel_t b;
    ld_t   ld;
  } instr_t;

  typedef struct packed {
    logic  start;
    logic  capture;
    op_t   op;
    rsel_t dst;
    rsel_t a;
    rsel_t b;
    ld_t   ld;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic sat;
    logic big;
  } dp_stat_t;

  typedef struct packed {
    logic        load;
    logic        mode;
    logic [11:0] ev;
  } res_t;

  // microprogram: load, norm, then one map step
  function automatic instr_t amet_rom(pc_t pc);
    instr_t r;
    r = '{OP_NOP, R_T0, R_T0, R_T0, LD_C_RE};
    unique case (pc)
      6'd0:  r = '{OP_LD,   R_KR,  R_T0,  R_T0,  LD_C_RE};
      6'd1:  r = '{OP_LD,   R_KI,  R_T0,  R_T0,  LD_C_IM};
      6'd2:  r = '{OP_LD,   R_XR,  R_T0,  R_T0,  LD_PT_RE};
      6'd3:  r = '{OP_LD,   R_XI,  R_T0,  R_T0,  LD_PT_IM};
      6'd4:  r = '{OP_MUL,  R_T0,  R_XR,  R_XR,  LD_C_RE};
      6'd5:  r = '{OP_MUL,  R_T1,  R_XI,  R_XI,  LD_C_RE};
      6'd6:  r = '{OP_ADD,  R_T2,  R_T0,  R_T1,  LD_C_RE};
      6'd7:  r = '{OP_MOV,  R_CR,  R_XR,  R_T0,  LD_C_RE};
      6'd8:  r = '{OP_NEG,  R_CI,  R_XI,  R_T0,  LD_C_RE};
      6'd9:  r = '{OP_MOV,  R_PR,  R_CR,  R_T0,  LD_C_RE};
      6'd10: r = '{OP_MOV,  R_PI,  R_CI,  R_T0,  LD_C_RE};
      6'd11: r = '{OP_MOV,  R_Y1R, R_CR,  R_T0,  LD_C_RE};
      6'd12: r = '{OP_MOV,  R_Y1I, R_CI,  R_T0,  LD_C_RE};
      6'd13: r = '{OP_MOV,  R_Y2R, R_CR,  R_T0,  LD_C_RE};
      6'd14: r = '{OP_MOV,  R_Y2I, R_CI,  R_T0,  LD_C_RE};
      6'd15: r = '{OP_LOOP, R_T0,  R_T0,  R_T0,  LD_C_RE};
      6'd16: r = '{OP_MUL,  R_T0,  R_PR,  R_CR,  LD_C_RE};
      6'd17: r = '{OP_MUL,  R_T1,  R_PI,  R_CI,  LD_C_RE};
      6'd18: r = '{OP_MUL,  R_T2,  R_PR,  R_CI,  LD_C_RE};
      6'd19: r = '{OP_MUL,  R_T3,  R_PI,  R_CR,  LD_C_RE};
      6'd20: r = '{OP_SUB,  R_PR,  R_T0,  R_T1,  LD_C_RE};
      6'd21: r = '{OP_ADD,  R_PI,  R_T2,  R_T3,  LD_C_RE};
      6'd22: r = '{OP_MOVN, R_Y1R, R_PR,  R_T0,  LD_C_RE};
      6'd23: r = '{OP_MOVN, R_Y1I, R_PI,  R_T0,  LD_C_RE};
      6'd24: r = '{OP_MOVM, R_Y2R, R_PR,  R_T0,  LD_C_RE};
      6'd25: r = '{OP_MOVM, R_Y2I, R_PI,  R_T0,  LD_C_RE};
      6'd26: r = '{OP_MUL,  R_T0,  R_KR,  R_Y2R, LD_C_RE};
      6'd27: r = '{OP_MUL,  R_T1,  R_KI,  R_Y2I, LD_C_RE};
      6'd28: r = '{OP_ADD,  R_T2,  R_T0,  R_T1,  LD_C_RE};
      6'd29: r = '{OP_MUL,  R_T0,  R_KI,  R_Y2R, LD_C_RE};
      6'd30: r = '{OP_MUL,  R_T1,  R_KR,  R_Y2I, LD_C_RE};
      6'd31: r = '{OP_SUB,  R_T3,  R_T0,  R_T1,  LD_C_RE};
      6'd32: r = '{OP_MUL,  R_T0,  R_Y2R, R_Y2R, LD_C_RE};
      6'd33: r = '{OP_MUL,  R_T1,  R_Y2I, R_Y2I, LD_C_RE};
      6'd34: r = '{OP_ADD,  R_PR,  R_T0,  R_T1,  LD_C_RE};
      6'd35: r = '{OP_DIV,  R_T0,  R_T2,  R_PR,  LD_C_RE};
      6'd36: r = '{OP_ADD,  R_XR,  R_Y1R, R_T0,  LD_C_RE};
      6'd37: r = '{OP_DIV,  R_T0,  R_T3,  R_PR,  LD_C_RE};
      6'd38: r = '{OP_ADD,  R_XI,  R_Y1I, R_T0,  LD_C_RE};
      default: r = '{OP_NOP, R_T0, R_T0, R_T0, LD_C_RE};
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/amet_point_if.sv =====
// ----------------------------------------------------------------------------
// amet_point_if
// Input channel: mode and start point, valid/ready.
// ----------------------------------------------------------------------------
interface amet_point_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [63:0] point_real;
  logic signed [63:0] point_imag;
  modport source (output valid, mode, point_real, point_imag, input ready);
  modport sink   (input valid, mode, point_real, point_imag, output ready);
endinterface

// ===== hw/rtl/amet_result_if.sv =====
// ----------------------------------------------------------------------------
// amet_result_if
// Output channel: escape value and next point, valid/ready.
// ----------------------------------------------------------------------------
interface amet_result_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] escape_value;
  logic signed [63:0] next_real;
  logic signed [63:0] next_imag;
  modport source (output valid, escape_value, next_real, next_imag, input ready);
  modport sink   (input valid, escape_value, next_real, next_imag, output ready);
endinterface

// ===== hw/rtl/amet_datapath.sv =====
// ----------------------------------------------------------------------------
// amet_datapath
// Q16.48 register file, saturating ALU, split multiplier, serial divider.
// ----------------------------------------------------------------------------
module amet_datapath import amet_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  input  logic signed [63:0] c_real,
  input  logic signed [63:0] c_imag,
  input  logic signed [63:0] point_real,
  input  logic signed [63:0] point_imag,
  output dp_stat_t           stat,
  output logic signed [63:0] res_real,
  output logic signed [63:0] res_imag
);

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001, PH_EXEC = 5'b00010, PH_MUL = 5'b00100,
    PH_DIV = 5'b01000, PH_DFIN = 5'b10000
  } ph_t;

  function automatic logic [64:0] sat_add(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return {1'b1, a[63] ? FX_MIN : FX_MAX};
    return {1'b0, s};
  endfunction

  function automatic logic [64:0] sat_sub(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) return {1'b1, a[63] ? FX_MIN : FX_MAX};
    return {1'b0, s};
  endfunction

  function automatic logic [64:0] from_mag(logic neg, logic [63:0] mag, logic over);
    if (neg) begin
      if (over || mag > 64'h8000_0000_0000_0000) return {1'b1, FX_MIN};
      return {1'b0, 64'd0 - mag};
    end
    if (over || mag[63]) return {1'b1, FX_MAX};
    return {1'b0, mag};
  endfunction

  function automatic logic [63:0] mag_of(logic signed [63:0] a);
    return a[63] ? 64'd0 - a : a;
  endfunction

  logic signed [63:0] rf [16];
  logic signed [63:0] rda, rdb, pt_re, pt_im;
  op_t   op_q;
  rsel_t dst_q;
  ld_t   ld_q;
  ph_t   ph;
  logic  sat, big, done;

  // multiplier / divider working registers
  logic [63:0]  ma, mb, prod, ud, dr, dlo, dq;
  logic [1:0]   psh;
  logic [127:0] acc, rnd;
  logic [2:0]   mcnt;
  logic [6:0]   dcnt;
  logic         neg;

  logic         wr_en;
  logic [64:0]  wr_res;
  logic [64:0]  dsh;
  logic [63:0]  un;
  logic [31:0]  fa, fb;
  ph_t          ph_next;

  assign un  = mag_of(rda);
  assign rnd = acc + RND_HALF;
  assign dsh = {dr, dlo[63]};

  always_comb begin
    unique case (mcnt[1:0])
      2'd0:    begin fa = ma[31:0];  fb = mb[31:0];  end
      2'd1:    begin fa = ma[31:0];  fb = mb[63:32]; end
      2'd2:    begin fa = ma[63:32]; fb = mb[31:0];  end
      default: begin fa = ma[63:32]; fb = mb[63:32]; end
    endcase
  end

  // write-back select
  always_comb begin
    wr_en   = 1'b0;
    wr_res  = '0;
    ph_next = ph;
    priority case (1'b1)
      ph[0]: if (cmd.start) ph_next = PH_EXEC;
      ph[1]: begin
        ph_next = PH_IDLE;
        unique case (op_q)
          OP_LD: begin
            wr_en = 1'b1;
            unique case (ld_q)
              LD_C_RE:  wr_res = {1'b0, c_real};
              LD_C_IM:  wr_res = {1'b0, c_imag};
              LD_PT_RE: wr_res = {1'b0, pt_re};
              default:  wr_res = {1'b0, pt_im};
            endcase
          end
          OP_MOV: begin wr_en = 1'b1; wr_res = {1'b0, rda}; end
          OP_NEG: begin
            wr_en  = 1'b1;
            wr_res = (rda == FX_MIN) ? {1'b1, FX_MAX} : {1'b0, -rda};
          end
          OP_ADD: begin wr_en = 1'b1; wr_res = sat_add(rda, rdb); end
          OP_SUB: begin wr_en = 1'b1; wr_res = sat_sub(rda, rdb); end
          OP_MUL: ph_next = PH_MUL;
          OP_DIV: begin
            if (rdb == 64'sd0) begin
              wr_en  = 1'b1;
              wr_res = {1'b1, rda[63] ? FX_MIN : FX_MAX};
            end else if ({16'd0, un[63:16]} >= mag_of(rdb)) begin
              wr_en  = 1'b1;
              wr_res = from_mag(rda[63] ^ rdb[63], 64'd0, 1'b1);
            end else begin
              ph_next = PH_DIV;
            end
          end
          default: ;
        endcase
      end
      ph[2]: if (mcnt == 3'd5) begin
        wr_en   = 1'b1;
        wr_res  = from_mag(neg, rnd[111:48], |rnd[127:112]);
        ph_next = PH_IDLE;
      end
      ph[3]: if (dcnt == 7'd63) ph_next = PH_DFIN;
      default: begin
        wr_en   = 1'b1;
        wr_res  = from_mag(neg, dq, 1'b0);
        ph_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= PH_IDLE;
      done <= 1'b0;
      sat  <= 1'b0;
      big  <= 1'b0;
    end else begin
      ph   <= ph_next;
      done <= wr_en;
      if (cmd.capture) sat <= 1'b0;
      else if (wr_en && wr_res[64]) sat <= 1'b1;
      if (wr_en) big <= $signed(wr_res[63:0]) >= ESC_NORM;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pt_re <= point_real;
      pt_im <= point_imag;
    end
    if (cmd.start) begin
      rda   <= rf[cmd.a];
      rdb   <= rf[cmd.b];
      op_q  <= cmd.op;
      dst_q <= cmd.dst;
      ld_q  <= cmd.ld;
    end
    if (wr_en) begin
      rf[dst_q] <= wr_res[63:0];
      if (dst_q == R_XR) res_real <= wr_res[63:0];
      if (dst_q == R_XI) res_imag <= wr_res[63:0];
    end
    // operand setup
    if (ph == PH_EXEC) begin
      ma   <= un;
      mb   <= mag_of(rdb);
      ud   <= mag_of(rdb);
      neg  <= rda[63] ^ rdb[63];
      acc  <= '0;
      mcnt <= 3'd0;
      dr   <= {16'd0, un[63:16]};
      dlo  <= {un[15:0], 48'd0};
      dq   <= '0;
      dcnt <= 7'd0;
    end
    // four 32x32 partial products, product registered before accumulate
    if (ph == PH_MUL) begin
      mcnt <= mcnt + 3'd1;
      if (mcnt < 3'd4) begin
        prod <= fa * fb;
        psh  <= mcnt[1:0];
      end
      if (mcnt != 3'd0 && mcnt != 3'd5) begin
        unique case (psh)
          2'd0:    acc <= acc + {64'd0, prod};
          2'd3:    acc <= acc + {prod, 64'd0};
          default: acc <= acc + {32'd0, prod, 32'd0};
        endcase
      end
    end
    // restoring division, one quotient bit a cycle
    if (ph == PH_DIV) begin
      dcnt <= dcnt + 7'd1;
      dlo  <= {dlo[62:0], 1'b0};
      if (dsh[64] || dsh[63:0] >= ud) begin
        dr <= dsh[63:0] - ud;
        dq <= {dq[62:0], 1'b1};
      end else begin
        dr <= dsh[63:0];
        dq <= {dq[62:0], 1'b0};
      end
    end
  end

  assign stat = '{done: done, sat: sat, big: big};

endmodule

// ===== hw/rtl/amet_ctrl.sv =====
// ----------------------------------------------------------------------------
// amet_ctrl
// Microprogram sequencer: iteration count, power loop, escape decision.
// ----------------------------------------------------------------------------
`include "anti_mcmullen_escape_time_top_defines.svh"

module amet_ctrl import amet_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_mode,
  output logic       in_ready,
  input  logic       out_busy,
  input  logic [3:0] exp_n,
  input  logic [3:0] exp_m,
  input  logic [9:0] max_it,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd,
  output res_t       res
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_ISSUE = 4'b0010, S_WAIT = 4'b0100, S_DONE = 4'b1000
  } state_t;

  state_t      state, state_next;
  pc_t         pc, pc_next, pc_adv;
  logic [9:0]  iter, iter_next, iter_adv;
  logic [3:0]  j, j_next, j_adv;
  logic [11:0] ev, ev_next, ev_adv;
  logic        mode;
  logic        fin, skip, adv, accept;
  logic [3:0]  n, m, top;
  instr_t      ins;

  assign n   = (exp_n == 4'd0) ? 4'd1 : (exp_n > MAX_EXPONENT) ? MAX_EXPONENT : exp_n;
  assign m   = (exp_m == 4'd0) ? 4'd1 : (exp_m > MAX_EXPONENT) ? MAX_EXPONENT : exp_m;
  assign top = (n > m) ? n : m;
  assign ins = amet_rom(pc);

  assign skip = (ins.op == OP_LOOP) ||
                (ins.op == OP_MOVN && j + 4'd1 != n) ||
                (ins.op == OP_MOVM && j + 4'd1 != m);

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.start   = (state == S_ISSUE) && !skip;
    cmd.capture = accept;
    cmd.op      = (ins.op == OP_MOVN || ins.op == OP_MOVM) ? OP_MOV : ins.op;
    cmd.dst     = ins.dst;
    cmd.a       = ins.a;
    cmd.b       = ins.b;
    cmd.ld      = ins.ld;
  end

  // sequencing after an instruction completes
  always_comb begin
    fin      = 1'b0;
    pc_adv   = pc + 6'd1;
    j_adv    = j;
    iter_adv = iter;
    ev_adv   = ev;
    priority if (pc == PC_LD_END && mode) begin
      pc_adv = PC_STEP;
      j_adv  = 4'd1;
    end else if (pc == PC_NORM_END) begin
      if (iter < max_it && !(stat.sat || stat.big)) begin
        pc_adv = PC_STEP;
        j_adv  = 4'd1;
      end else begin
        fin    = 1'b1;
        ev_adv = (iter < max_it) ? {1'b0, iter, 1'b0} : EV_NONE;
      end
    end else if (pc == PC_LOOP) begin
      if (j >= top) pc_adv = PC_LOOP_END + 6'd1;
    end else if (pc == PC_LOOP_END) begin
      j_adv  = j + 4'd1;
      pc_adv = PC_LOOP;
    end else if (pc == PC_STEP_END) begin
      if (mode) begin
        fin    = 1'b1;
        ev_adv = '0;
      end else begin
        iter_adv = iter + 10'd1;
        pc_adv   = PC_NORM;
      end
    end
  end

  assign adv = (state == S_ISSUE && skip) || (state == S_WAIT && stat.done);

  always_comb begin
    state_next = state;
    pc_next    = pc;
    iter_next  = iter;
    j_next     = j;
    ev_next    = ev;
    res.load   = 1'b0;
    if (adv) begin
      pc_next   = pc_adv;
      iter_next = iter_adv;
      j_next    = j_adv;
      ev_next   = ev_adv;
    end
    unique case (state)
      S_IDLE: if (accept) begin
        state_next = S_ISSUE;
        pc_next    = '0;
        iter_next  = '0;
      end
      S_ISSUE: begin
        if (!skip) state_next = S_WAIT;
        else if (fin) state_next = S_DONE;
      end
      S_WAIT: if (stat.done) state_next = fin ? S_DONE : S_ISSUE;
      S_DONE: if (!out_busy) begin
        res.load   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign res.mode = mode;
  assign res.ev   = ev;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pc    <= '0;
      iter  <= '0;
      j     <= 4'd1;
      ev    <= '0;
    end else begin
      state <= state_next;
      pc    <= pc_next;
      iter  <= iter_next;
      j     <= j_next;
      ev    <= ev_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) mode <= in_mode;
  end

  `AMET_ASSERT_SAME(a_start_in_issue, cmd.start, state == S_ISSUE)
  `AMET_ASSERT_SAME(a_done_in_wait, stat.done, state == S_WAIT)
  `AMET_ASSERT_NEXT(a_accept_issues, accept, state == S_ISSUE && pc == '0)
  `AMET_ASSERT_SAME(a_load_free, res.load, !out_busy && state == S_DONE)

endmodule

// ===== hw/rtl/anti_mcmullen_escape_time_top.sv =====
// ----------------------------------------------------------------------------
// anti_mcmullen_escape_time_top
// Escape-time iteration of x -> conj(x)^n + c/conj(x)^m in Q16.48.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake       | word contents
//  point    | in  | valid/ready     | mode, point_real, point_imag
//  result   | out | valid/ready     | escape_value, next_real, next_imag
//  apb      | in  | psel/penable    | c_real, c_imag, exponent_n/m, max_iterations
//
//  One word at a time. Each map step is a microprogram run on one shared
//  ALU: a product is built from four 32x32 partial products, a quotient
//  by a restoring divider, one bit a cycle. Mode 0 checks the norm before
//  each step and counts the steps; mode 1 runs a single step. Reset (rst,
//  sync) clears control state and loads the configuration defaults; the
//  datapath registers are not reset. A finished result sits in the output
//  register; the next word is taken while it waits, and a later result
//  stalls only if it is still unread.
// ----------------------------------------------------------------------------
module anti_mcmullen_escape_time_top import amet_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  amet_point_if.sink    point,
  amet_result_if.source result,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready
);

  // configuration registers
  logic signed [63:0] c_real, c_imag;
  logic [3:0]         exp_n, exp_m;
  logic [9:0]         max_it;
  logic               cfg_wr;
  reg_idx_t           widx;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign widx   = reg_idx_t'(paddr[5:3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_real <= 64'sd2814750;
      c_imag <= '0;
      exp_n  <= 4'd3;
      exp_m  <= 4'd3;
      max_it <= 10'd100;
    end else if (cfg_wr) begin
      unique case (widx)
        REG_C_REAL: c_real <= pwdata;
        REG_C_IMAG: c_imag <= pwdata;
        REG_EXP_N:  exp_n  <= pwdata[3:0];
        REG_EXP_M:  exp_m  <= pwdata[3:0];
        REG_MAX_IT: max_it <= pwdata[9:0];
        default: ;   // unmapped address, dropped
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_C_REAL: prdata = c_real;
      REG_C_IMAG: prdata = c_imag;
      REG_EXP_N:  prdata = {60'd0, exp_n};
      REG_EXP_M:  prdata = {60'd0, exp_m};
      REG_MAX_IT: prdata = {54'd0, max_it};
      default:    prdata = '0;
    endcase
  end

  // controller <-> datapath
  dp_cmd_t            cmd;
  dp_stat_t           stat;
  res_t               res;
  logic signed [63:0] res_real, res_imag;
  logic               out_busy;

  // output register: busy while a word waits unread
  assign out_busy = result.valid && !result.ready;

  amet_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (point.valid),
    .in_mode  (point.mode),
    .in_ready (point.ready),
    .out_busy (out_busy),
    .exp_n    (exp_n),
    .exp_m    (exp_m),
    .max_it   (max_it),
    .stat     (stat),
    .cmd      (cmd),
    .res      (res)
  );

  amet_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .c_real     (c_real),
    .c_imag     (c_imag),
    .point_real (point.point_real),
    .point_imag (point.point_imag),
    .stat       (stat),
    .res_real   (res_real),
    .res_imag   (res_imag)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (res.load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  // mode 1 carries the new point, mode 0 the count
  always_ff @(posedge clk) begin
    if (res.load) begin
      result.escape_value <= res.ev;
      result.next_real    <= res.mode ? res_real : 64'sd0;
      result.next_imag    <= res.mode ? res_imag : 64'sd0;
    end
  end

endmodule
